>>> rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the ray and plane crossing unit
// Widths of the dot products, the divider and the pipeline records.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int POS_W     = 32;
	localparam int DIR_W     = 16;
	localparam int DIFF_W    = POS_W + 1;
	localparam int NPLP_W    = 2 * DIR_W;
	localparam int NUMP_W    = DIFF_W + DIR_W;
	localparam int NPL_W     = NPLP_W + 2;
	localparam int NUM_W     = NUMP_W + 2;
	localparam int MAG_W     = 49;
	localparam int DEN_W     = 32;
	localparam int PROD_W    = 64;
	localparam int QUO_W     = 34;
	localparam int DIV_STEPS = QUO_W;
	localparam int TAG_DEPTH = DIV_STEPS + 2;

	localparam logic [2:0] REG_POINT_X  = 3'd0;
	localparam logic [2:0] REG_POINT_Y  = 3'd1;
	localparam logic [2:0] REG_POINT_Z  = 3'd2;
	localparam logic [2:0] REG_NORMAL_X = 3'd3;
	localparam logic [2:0] REG_NORMAL_Y = 3'd4;
	localparam logic [2:0] REG_NORMAL_Z = 3'd5;

	typedef enum logic [1:0] {
		OUT_CROSS    = 2'd0,
		OUT_PARALLEL = 2'd1,
		OUT_BACK     = 2'd2,
		OUT_BEHIND   = 2'd3
	} outcome_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [DIR_W-1:0] nx;
		logic signed [DIR_W-1:0] ny;
		logic signed [DIR_W-1:0] nz;
	} plane_t;

	typedef struct packed {
		logic                valid;
		outcome_t            outcome;
	} tag_t;

	typedef struct packed {
		logic [PROD_W-1:0]       prod;
		logic [DEN_W-1:0]        den;
		logic                    neg;
		logic signed [POS_W-1:0] start;
		logic                    ok;
	} lane_in_t;

	typedef struct packed {
		logic [DEN_W-1:0]        rem;
		logic [QUO_W-1:0]        quo;
		logic [QUO_W-1:0]        low;
		logic [DEN_W-1:0]        den;
		logic                    neg;
		logic signed [POS_W-1:0] start;
		logic                    ok;
		logic                    ovf;
	} div_t;

endpackage

>>> rtl/rpc_front.sv
// ----------------------------------------------------------------------------
// rpc_front: dot products, classification and offset numerators
// Five register stages from the ray to the three divider lane inputs.
// ----------------------------------------------------------------------------
module rpc_front import rpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [POS_W-1:0] start_in [3],
	input  logic signed [DIR_W-1:0] dir_in [3],
	input  plane_t                  plane,
	output tag_t                    tag_s5,
	output lane_in_t                lane_s5 [3]
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [POS_W-1:0]  pp_a [3];
	logic signed [DIR_W-1:0]  nrm_a [3];

	logic signed [DIFF_W-1:0] diff_s1 [3];
	logic signed [POS_W-1:0]  start_s1 [3];
	logic signed [DIR_W-1:0]  dir_s1 [3];

	logic signed [NPLP_W-1:0] nplp_s2 [3];
	logic signed [NUMP_W-1:0] nump_s2 [3];
	logic signed [POS_W-1:0]  start_s2 [3];
	logic signed [DIR_W-1:0]  dir_s2 [3];

	logic signed [NPL_W-1:0]  npl_s3;
	logic signed [NUM_W-1:0]  num_s3;
	logic signed [POS_W-1:0]  start_s3 [3];
	logic signed [DIR_W-1:0]  dir_s3 [3];

	outcome_t                 outcome_s4;
	logic [MAG_W-1:0]         numm_s4;
	logic [DEN_W-1:0]         den_s4;
	logic [DIR_W-1:0]         dmag_s4 [3];
	logic                     neg_s4 [3];
	logic signed [POS_W-1:0]  start_s4 [3];

	logic [NUM_W-1:0]         num_abs;
	logic [NPL_W-1:0]         npl_abs;
	logic [DIR_W-1:0]         dir_abs [3];
	logic [PROD_W:0]          prod_c [3];
	outcome_t                 outcome_c;

	always_comb begin
		pp_a[0]  = plane.px;
		pp_a[1]  = plane.py;
		pp_a[2]  = plane.pz;
		nrm_a[0] = plane.nx;
		nrm_a[1] = plane.ny;
		nrm_a[2] = plane.nz;
	end

	always_comb begin
		num_abs = num_s3[NUM_W-1] ? -num_s3 : num_s3;
		npl_abs = npl_s3[NPL_W-1] ? -npl_s3 : npl_s3;
		for (int i = 0; i < 3; i++) begin
			dir_abs[i] = dir_s3[i][DIR_W-1] ? -dir_s3[i] : dir_s3[i];
		end
		// Parallel first, then approach from the back, then crossing behind the start.
		if (npl_s3 == '0) begin
			outcome_c = OUT_PARALLEL;
		end else if (!npl_s3[NPL_W-1]) begin
			outcome_c = OUT_BACK;
		end else if (!num_s3[NUM_W-1] && num_s3 != '0) begin
			outcome_c = OUT_BEHIND;
		end else begin
			outcome_c = OUT_CROSS;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = {{(PROD_W+1-MAG_W){1'b0}}, numm_s4}
				* {{(PROD_W+1-DIR_W){1'b0}}, dmag_s4[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			tag_s5 <= '0;
		end else if (en) begin
			v_s1           <= in_valid;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			tag_s5.valid   <= v_s4;
			tag_s5.outcome <= outcome_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				diff_s1[i]  <= DIFF_W'(pp_a[i]) - DIFF_W'(start_in[i]);
				start_s1[i] <= start_in[i];
				dir_s1[i]   <= dir_in[i];

				nplp_s2[i]  <= NPLP_W'(dir_s1[i]) * NPLP_W'(nrm_a[i]);
				nump_s2[i]  <= NUMP_W'(diff_s1[i]) * NUMP_W'(nrm_a[i]);
				start_s2[i] <= start_s1[i];
				dir_s2[i]   <= dir_s1[i];

				start_s3[i] <= start_s2[i];
				dir_s3[i]   <= dir_s2[i];

				dmag_s4[i]  <= dir_abs[i];
				neg_s4[i]   <= dir_s3[i][DIR_W-1];
				start_s4[i] <= start_s3[i];

				lane_s5[i].prod  <= prod_c[i][PROD_W-1:0];
				lane_s5[i].den   <= den_s4;
				lane_s5[i].neg   <= neg_s4[i];
				lane_s5[i].start <= start_s4[i];
				lane_s5[i].ok    <= (outcome_s4 == OUT_CROSS);
			end
			npl_s3 <= NPL_W'(nplp_s2[0]) + NPL_W'(nplp_s2[1]) + NPL_W'(nplp_s2[2]);
			num_s3 <= NUM_W'(nump_s2[0]) + NUM_W'(nump_s2[1]) + NUM_W'(nump_s2[2]);

			outcome_s4 <= outcome_c;
			numm_s4    <= num_abs[MAG_W-1:0];
			den_s4     <= npl_abs[DEN_W-1:0];
		end
	end

endmodule

>>> rtl/rpc_div.sv
// ----------------------------------------------------------------------------
// rpc_div: pipelined restoring divider for one coordinate offset
// One quotient bit per stage, then rounding, offset add and clipping.
// ----------------------------------------------------------------------------
module rpc_div import rpc_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  lane_in_t                din,
	output logic signed [POS_W-1:0] coord,
	output logic                    sat
);

	localparam int HI_W = PROD_W - QUO_W;
	localparam logic signed [QUO_W+1:0] SUM_MAX =
		{{(QUO_W+3-POS_W){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [QUO_W+1:0] SUM_MIN =
		{{(QUO_W+3-POS_W){1'b1}}, {(POS_W-1){1'b0}}};

	div_t st [DIV_STEPS+1];

	logic [DEN_W:0]   rem2 [DIV_STEPS];
	logic             ge   [DIV_STEPS];
	logic [DEN_W:0]   remd [DIV_STEPS];

	logic             rnd;
	logic [QUO_W:0]   qr;
	logic             big;
	logic signed [QUO_W+1:0] sum;
	logic signed [QUO_W+1:0] off;
	logic signed [POS_W-1:0] val;
	logic             clip;

	// Quotients of 2^QUO_W or more saturate in every case, so the high
	// part of the product only has to be compared once against the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			st[0].rem   <= DEN_W'(din.prod[PROD_W-1:QUO_W]);
			st[0].quo   <= '0;
			st[0].low   <= din.prod[QUO_W-1:0];
			st[0].den   <= din.den;
			st[0].neg   <= din.neg;
			st[0].start <= din.start;
			st[0].ok    <= din.ok;
			st[0].ovf   <= {{(DEN_W-HI_W){1'b0}}, din.prod[PROD_W-1:QUO_W]} >= din.den;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		always_comb begin
			rem2[k] = {st[k].rem, st[k].low[QUO_W-1]};
			ge[k]   = rem2[k] >= {1'b0, st[k].den};
			remd[k] = ge[k] ? rem2[k] - {1'b0, st[k].den} : rem2[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].rem   <= remd[k][DEN_W-1:0];
				st[k+1].quo   <= {st[k].quo[QUO_W-2:0], ge[k]};
				st[k+1].low   <= {st[k].low[QUO_W-2:0], 1'b0};
				st[k+1].den   <= st[k].den;
				st[k+1].neg   <= st[k].neg;
				st[k+1].start <= st[k].start;
				st[k+1].ok    <= st[k].ok;
				st[k+1].ovf   <= st[k].ovf;
			end
		end
	end

	always_comb begin
		rnd  = {st[DIV_STEPS].rem, 1'b0} >= {1'b0, st[DIV_STEPS].den};
		qr   = {1'b0, st[DIV_STEPS].quo} + (QUO_W+1)'(rnd);
		big  = st[DIV_STEPS].ovf || qr[QUO_W:QUO_W-1] != 2'b00;
		off  = st[DIV_STEPS].neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
		sum  = (QUO_W+2)'(st[DIV_STEPS].start) + off;
		clip = 1'b0;
		val  = sum[POS_W-1:0];
		if (big) begin
			clip = 1'b1;
			val  = st[DIV_STEPS].neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else if (sum > SUM_MAX) begin
			clip = 1'b1;
			val  = {1'b0, {(POS_W-1){1'b1}}};
		end else if (sum < SUM_MIN) begin
			clip = 1'b1;
			val  = {1'b1, {(POS_W-1){1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord <= st[DIV_STEPS].ok ? val : '0;
			sat   <= st[DIV_STEPS].ok && clip;
		end
	end

endmodule

>>> rtl/ray_plane_crossing_unit.sv
// ----------------------------------------------------------------------------
// ray_plane_crossing_unit: crossing point of a ray with a configured plane
// Top level: register file, front end, three divider lanes, output stage.
// ----------------------------------------------------------------------------
// A ray enters as one transaction on the s_ channel: start point x, y, z in
// Q15.16 and direction x, y, z in Q1.14. Each ray gives one transaction on
// the m_ channel: the crossing point in tdata, the outcome code and the
// saturation flag in tuser. Rejected rays return a zero point.
// The plane point and normal are written through the APB port while no ray
// is in flight, a rule the user keeps; the block does not enforce it. Reset
// loads the plane z = 0 with normal +z and empties the pipeline. There are
// five front stages (differences, products, dot products, classification,
// offset numerators), one divider set-up stage, 34 divider stages of one
// quotient bit each, and the output register. Throughput is one ray per
// cycle unless the receiver stalls. The whole pipeline moves as one; when
// the receiver holds m_tready low with a result waiting, every stage holds
// and s_tready drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_plane_crossing_unit import rpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_z, dir_x, dir_y, dir_z
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cross_x, cross_y, cross_z
	output logic [95:0]  m_tdata,
	// outcome, saturated
	output logic [2:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	plane_t   plane_q;
	logic     en;
	logic [2:0] reg_idx;

	logic signed [POS_W-1:0] start_in [3];
	logic signed [DIR_W-1:0] dir_in [3];
	tag_t     tag_s5;
	lane_in_t lane_s5 [3];
	tag_t     tag_d [TAG_DEPTH];
	logic signed [POS_W-1:0] coord [3];
	logic     sat [3];

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.px <= '0;
			plane_q.py <= '0;
			plane_q.pz <= '0;
			plane_q.nx <= '0;
			plane_q.ny <= '0;
			plane_q.nz <= DIR_W'(16384);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_POINT_X:  plane_q.px <= pwdata;
				REG_POINT_Y:  plane_q.py <= pwdata;
				REG_POINT_Z:  plane_q.pz <= pwdata;
				REG_NORMAL_X: plane_q.nx <= pwdata[DIR_W-1:0];
				REG_NORMAL_Y: plane_q.ny <= pwdata[DIR_W-1:0];
				REG_NORMAL_Z: plane_q.nz <= pwdata[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_POINT_X:  prdata = plane_q.px;
			REG_POINT_Y:  prdata = plane_q.py;
			REG_POINT_Z:  prdata = plane_q.pz;
			REG_NORMAL_X: prdata = 32'(plane_q.nx);
			REG_NORMAL_Y: prdata = 32'(plane_q.ny);
			REG_NORMAL_Z: prdata = 32'(plane_q.nz);
			default:      prdata = '0;
		endcase
	end

	assign m_tvalid = tag_d[TAG_DEPTH-1].valid;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		start_in[0] = s_tdata[31:0];
		start_in[1] = s_tdata[63:32];
		start_in[2] = s_tdata[95:64];
		dir_in[0]   = s_tdata[111:96];
		dir_in[1]   = s_tdata[127:112];
		dir_in[2]   = s_tdata[143:128];
	end

	rpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.start_in (start_in),
		.dir_in   (dir_in),
		.plane    (plane_q),
		.tag_s5   (tag_s5),
		.lane_s5  (lane_s5)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rpc_div u_div (
			.clk   (clk),
			.en    (en),
			.din   (lane_s5[i]),
			.coord (coord[i]),
			.sat   (sat[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAG_DEPTH; k++) begin
				tag_d[k] <= '0;
			end
		end else if (en) begin
			tag_d[0] <= tag_s5;
			for (int k = 1; k < TAG_DEPTH; k++) begin
				tag_d[k] <= tag_d[k-1];
			end
		end
	end

	assign m_tdata = {coord[2], coord[1], coord[0]};
	assign m_tuser = {sat[0] | sat[1] | sat[2], tag_d[TAG_DEPTH-1].outcome};

endmodule

>>> tb/tb_ray_plane_crossing_unit.sv
// ----------------------------------------------------------------------------
// tb_ray_plane_crossing_unit: self-checking bench for the ray and plane unit
// Rays are driven on the s_ channel with random gaps. Each accepted ray is
// predicted in exact integer arithmetic, and every m_ transaction is checked
// against the oldest prediction. The plane is rewritten over APB between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_ray_plane_crossing_unit;
	import rpc_pkg::*;

	// Packed so that start_x sits in the lowest bits of tdata.
	typedef struct packed {
		logic signed [15:0] dz;
		logic signed [15:0] dy;
		logic signed [15:0] dx;
		logic signed [31:0] sz;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
	} ray_t;

	typedef struct {
		outcome_t           outcome;
		logic               sat;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
	} crossing_t;

	localparam int LATENCY = 41;
	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	ray_plane_crossing_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Plane as the bench sees it.
	logic signed [31:0] pl_px, pl_py, pl_pz;
	logic signed [15:0] pl_nx, pl_ny, pl_nz;

	ray_t      pending_rays[$];
	crossing_t expected_crossings[$];
	int        errors = 0;
	int        rays_sent = 0;
	int        results_seen = 0;
	int        outcome_count[4] = '{0, 0, 0, 0};
	int        sat_count = 0;
	int        idle_cycles = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	bit        hold_off = 0;
	bit        no_gaps = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic signed [31:0] axis_crossing(logic signed [31:0] start,
			logic signed [15:0] d, logic [63:0] numm, logic [63:0] den, ref logic sat);
		logic [63:0]  dm;
		logic [127:0] p;
		logic [127:0] q;
		logic [127:0] r;
		logic signed [95:0] sum;
		dm = (d < 0) ? 64'(-64'(d)) : 64'(d);
		p = 128'(numm) * 128'(dm);
		q = p / den;
		r = p % den;
		if (r >= 128'(den) - r)
			q = q + 1;
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		sum = 96'(start) + ((d < 0) ? -$signed(96'(q)) : $signed(96'(q)));
		if (sum > 96'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (sum < -96'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return sum[31:0];
	endfunction

	function automatic crossing_t cross_plane(ray_t r);
		crossing_t c;
		logic signed [63:0] npl;
		logic signed [63:0] num;
		logic               sat;
		logic [63:0]        numm;
		logic [63:0]        den;
		npl = 64'(r.dx) * 64'(pl_nx) + 64'(r.dy) * 64'(pl_ny) + 64'(r.dz) * 64'(pl_nz);
		num = 64'(pl_nx) * (64'(pl_px) - 64'(r.sx)) + 64'(pl_ny) * (64'(pl_py) - 64'(r.sy))
			+ 64'(pl_nz) * (64'(pl_pz) - 64'(r.sz));
		c.sat = 1'b0;
		c.cx = '0;
		c.cy = '0;
		c.cz = '0;
		sat = 1'b0;
		if (npl == 0)
			c.outcome = OUT_PARALLEL;
		else if (npl > 0)
			c.outcome = OUT_BACK;
		else if (num > 0)
			c.outcome = OUT_BEHIND;
		else begin
			c.outcome = OUT_CROSS;
			numm = -num;
			den = -npl;
			c.cx = axis_crossing(r.sx, r.dx, numm, den, sat);
			c.cy = axis_crossing(r.sy, r.dy, numm, den, sat);
			c.cz = axis_crossing(r.sz, r.dz, numm, den, sat);
			c.sat = sat;
		end
		return c;
	endfunction

	function automatic int pick_gap();
		if (no_gaps)
			return 0;
		if ($urandom_range(99) < 3)
			return $urandom_range(60, 15);
		if ($urandom_range(99) < 55)
			return 0;
		return $urandom_range(3, 1);
	endfunction

	function automatic logic signed [15:0] rand_dir();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sh8000;
			3: return 16'sd0;
			4: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			default: return 32'($signed($urandom_range(8388608)) - 4194304);
		endcase
	endfunction

	// Driver: present the next pending ray, with random gaps between rays.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_crossings.push_back(cross_plane(ray_t'(s_tdata)));
				rays_sent <= rays_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || hold_off || pending_rays.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left > 0)
						gap_left <= gap_left - 1;
				end else begin
					s_tdata  <= pending_rays.pop_front();
					s_tvalid <= 1'b1;
					gap_left <= pick_gap();
				end
			end
		end
	end

	// Monitor: random back-pressure and comparison against the prediction.
	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_crossings.size() == 0) begin
					$error("result with no ray outstanding");
					errors++;
				end else begin
					e = expected_crossings.pop_front();
					outcome_count[e.outcome]++;
					if (e.sat)
						sat_count++;
					if (m_tuser[1:0] !== e.outcome) begin
						$error("outcome: expected %0d, got %0d", e.outcome, m_tuser[1:0]);
						errors++;
					end
					if (m_tuser[2] !== e.sat) begin
						$error("saturated: expected %0d, got %0d", e.sat, m_tuser[2]);
						errors++;
					end
					if ($signed(m_tdata[31:0]) !== e.cx) begin
						$error("cross_x: expected %0d, got %0d", e.cx, $signed(m_tdata[31:0]));
						errors++;
					end
					if ($signed(m_tdata[63:32]) !== e.cy) begin
						$error("cross_y: expected %0d, got %0d", e.cy, $signed(m_tdata[63:32]));
						errors++;
					end
					if ($signed(m_tdata[95:64]) !== e.cz) begin
						$error("cross_z: expected %0d, got %0d", e.cz, $signed(m_tdata[95:64]));
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready   <= 1'b1;
				stall_left <= pick_gap();
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("** ray_plane_crossing_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_POINT_X:  pl_px = value;
			REG_POINT_Y:  pl_py = value;
			REG_POINT_Z:  pl_pz = value;
			REG_NORMAL_X: pl_nx = value[15:0];
			REG_NORMAL_Y: pl_ny = value[15:0];
			default:      pl_nz = value[15:0];
		endcase
	endtask

	task automatic set_plane(input logic signed [31:0] px, py, pz,
			input logic signed [15:0] nx, ny, nz);
		write_reg(REG_POINT_X, px);
		write_reg(REG_POINT_Y, py);
		write_reg(REG_POINT_Z, pz);
		write_reg(REG_NORMAL_X, 32'(nx));
		write_reg(REG_NORMAL_Y, 32'(ny));
		write_reg(REG_NORMAL_Z, 32'(nz));
	endtask

	task automatic drain();
		while (pending_rays.size() != 0 || s_tvalid || expected_crossings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic queue_ray(input logic signed [31:0] sx, sy, sz,
			input logic signed [15:0] dx, dy, dz);
		ray_t r;
		r.sx = sx; r.sy = sy; r.sz = sz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		pending_rays.push_back(r);
	endtask

	// Mostly rays aimed at the plane from the front, so that crossings dominate.
	task automatic random_phase(input int count);
		ray_t r;
		repeat (count) begin
			r.sx = rand_pos();
			r.sy = rand_pos();
			r.sz = rand_pos();
			r.dx = rand_dir();
			r.dy = rand_dir();
			r.dz = rand_dir();
			if ($urandom_range(99) < 65) begin
				if (64'(r.dx) * pl_nx + 64'(r.dy) * pl_ny + 64'(r.dz) * pl_nz > 0) begin
					r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
				end
			end
			pending_rays.push_back(r);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		pl_px = 0; pl_py = 0; pl_pz = 0;
		pl_nx = 0; pl_ny = 0; pl_nz = 16'sd16384;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rays against the reset plane z = 0, normal +z.
		queue_ray(0, 0, 32'sd65536, 0, 0, -16'sd16384);
		queue_ray(32'sd65536, 0, 0, 16'sd16384, 0, 0);
		queue_ray(0, 0, -32'sd65536, 0, 0, 16'sd16384);
		queue_ray(0, 0, -32'sd65536, 0, 0, -16'sd16384);
		queue_ray(5, 7, 0, 0, 0, -16'sd16384);
		queue_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd16384, -16'sd16384,
			-16'sd16384);
		queue_ray(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'sh8000, 16'sh7fff,
			-16'sd1);
		queue_ray(0, 0, 32'sh7fffffff, 16'sd16384, 0, -16'sd1);
		queue_ray(0, 0, 32'sh00030000, 16'sd11585, 0, -16'sd11585);
		queue_ray(32'sd3, 0, 32'sd1, 16'sd1, 16'sd1, -16'sd3);
		queue_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000,
			16'sh8000);
		queue_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'shffff, 16'shffff, 16'shffff);
		drain();

		// Extreme plane: point at the coordinate limits, most negative normal pattern in x.
		set_plane(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sd16384, 16'sh7fff);
		queue_ray(0, 0, 0, 16'sd16384, -16'sd16384, -16'sd16384);
		queue_ray(0, 0, 0, 16'sd1, -16'sd1, 16'sd0);
		random_phase(150);
		drain();

		// Hold the sender until the pipeline has emptied, then flow freely.
		set_plane(32'sd1 << 20, -32'sd3 << 18, 32'sd7 << 16, 16'sd9459, 16'sd9459, 16'sd9459);
		random_phase(60);
		repeat (30) @(posedge clk);
		hold_off = 1'b1;
		while (expected_crossings.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_off = 1'b0;
		no_gaps = 1'b1;
		random_phase(200);
		drain();
		no_gaps = 1'b0;

		set_plane(32'h80000000, 32'h80000000, 32'h80000000, -16'sd16384, 0, 16'sd0);
		random_phase(150);
		drain();

		repeat (3) begin
			set_plane(rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir());
			random_phase(130);
			drain();
		end

		$display("Covered %0d rays over seven planes: %0d crossings (%0d clipped), %0d parallel,",
			rays_sent, outcome_count[0], sat_count, outcome_count[1]);
		$display("%0d from the back, %0d behind the start; %0d results checked.",
			outcome_count[2], outcome_count[3], results_seen);
		if (errors == 0)
			$display("** ray_plane_crossing_unit: PASSED **");
		else
			$display("** ray_plane_crossing_unit: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rpc_pkg.sv
rtl/rpc_front.sv
rtl/rpc_div.sv
rtl/ray_plane_crossing_unit.sv
tb/tb_ray_plane_crossing_unit.sv
